### rtl/ccc_pkg.sv
// Shared types, constants and calendar helpers for the calendar clock counter.
// No dependencies; the other files in rtl/ that use it refer to this package by scoped names.
package ccc_pkg;

   // Word kinds on the request channel
   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_SET  = 1'b1
   } kind_type;

   localparam logic [5:0]  SEC_MAX   = 6'd59;
   localparam logic [5:0]  MIN_MAX   = 6'd59;
   localparam logic [4:0]  HOUR_MAX  = 5'd23;
   localparam logic [5:0]  FEB_SHORT = 6'd28;
   localparam logic [5:0]  FEB_LONG  = 6'd29;
   localparam logic [5:0]  DAYS_30   = 6'd30;
   localparam logic [5:0]  DAYS_31   = 6'd31;
   localparam logic [3:0]  MONTHS    = 4'd12;
   localparam logic [11:0] YEAR_LAST = 12'd2100;
   localparam logic [11:0] YEAR_WRAP = 12'd2020;

   // 25 * 3113 = 1 mod 4096: multiples of 25 map onto 0..163 under this product
   localparam logic [11:0] INV25       = 12'd3113;
   localparam logic [11:0] DIV25_LIMIT = 12'd163;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } time_type;

   typedef struct packed {
      kind_type kind;
      time_type set_time;
   } req_item_type;

   // Input register as seen by the time core
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   // Gregorian rule: divisible by 4 and not by 100, or divisible by 400
   function automatic logic is_leap(input logic [11:0] year);
      logic [23:0] prod;
      logic        div4;
      logic        div16;
      logic        div25;
      prod  = {12'd0, year} * {12'd0, INV25};
      div25 = (prod[11:0] <= DIV25_LIMIT);
      div4  = (year[1:0] == 2'd0);
      div16 = (year[3:0] == 4'd0);
      return (div4 && !div25) || (div16 && div25);
   endfunction

   // Month length; months outside 1 to 12 count as 31 days
   function automatic logic [5:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [5:0] days;
      unique case (month)
         4'd2:                      days = leap ? FEB_LONG : FEB_SHORT;
         4'd4, 4'd6, 4'd9, 4'd11:   days = DAYS_30;
         default:                   days = DAYS_31;
      endcase
      return days;
   endfunction

endpackage

### rtl/ccc_req_if.sv
// Request channel of the calendar clock counter: valid/ready plus one tick or set word.
// No dependencies.
interface ccc_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [11:0] set_year;
   logic [3:0]  set_month;
   logic [4:0]  set_day;
   logic [4:0]  set_hour;
   logic [5:0]  set_minute;
   logic [5:0]  set_second;

   modport source (output valid, kind, set_year, set_month, set_day, set_hour, set_minute,
                   set_second, input ready);
   modport sink   (input valid, kind, set_year, set_month, set_day, set_hour, set_minute,
                   set_second, output ready);
endinterface

### rtl/ccc_rsp_if.sv
// Response channel of the calendar clock counter: valid/ready plus the time after each word.
// No dependencies.
interface ccc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] out_year;
   logic [3:0]  out_month;
   logic [4:0]  out_day;
   logic [4:0]  out_hour;
   logic [5:0]  out_minute;
   logic [5:0]  out_second;

   modport source (output valid, out_year, out_month, out_day, out_hour, out_minute,
                   out_second, input ready);
   modport sink   (input valid, out_year, out_month, out_day, out_hour, out_minute,
                   out_second, output ready);
endinterface

### rtl/calendar_clock_counter.sv
// Top level of the calendar clock counter: input register stage and time core.
// Depends on ccc_pkg, ccc_req_if, ccc_rsp_if, ccc_in_reg and ccc_time_core.
//
// Calendar clock counter. Each request word is either a one-second tick or a set that
// loads year, month, day, hour, minute and second as given (no range check). Every
// word returns exactly one response word: the time after that word. A tick carries
// through the fields: seconds and minutes wrap after 59 (or anything above), hours
// after 23, the day after the month length (February 28 or 29 by the Gregorian rule,
// 31 for any month outside 1 to 12), the month after 12, and a year at or past 2100
// wraps to 2020. After reset the time reads all zeros. Throughput is one word per
// clock: the input register takes a word every cycle while the response side keeps
// up, and the time register, which also drives the response, is updated once per
// word. A request passes through the input register and then the time register,
// which presents its response. When the response is stalled the block still holds
// one more word in its input register before it drops ready.
module calendar_clock_counter (
   input  logic       clock,
   input  logic       reset,
   ccc_req_if.sink    req_port,
   ccc_rsp_if.source  rsp_port
);

   // Held request word, handed to the core
   ccc_pkg::stage_type stage;
   // Core takes the held word this cycle
   logic               advance;

   ccc_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .advance  (advance),
      .stage    (stage)
   );

   // Advance the time and present it; hold while the response is stalled
   ccc_time_core u_time_core (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .advance  (advance),
      .rsp_port (rsp_port)
   );

endmodule

### rtl/ccc_in_reg.sv
// Input register stage: captures one request word and holds it until the core takes it.
// Depends on ccc_pkg and ccc_req_if.
module ccc_in_reg (
   input  logic               clock,
   input  logic               reset,
   ccc_req_if.sink            req_port,
   input  logic               advance,
   output ccc_pkg::stage_type stage
);

   logic                  valid_ff;
   logic                  valid_in;
   ccc_pkg::req_item_type item_ff;
   ccc_pkg::req_item_type item_in;

   // Take a new word when empty or when the held one moves on this cycle
   assign req_port.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_port.valid && req_port.ready) begin
         valid_in                = 1'b1;
         item_in.kind            = ccc_pkg::kind_type'(req_port.kind);
         item_in.set_time.year   = req_port.set_year;
         item_in.set_time.month  = req_port.set_month;
         item_in.set_time.day    = req_port.set_day;
         item_in.set_time.hour   = req_port.set_hour;
         item_in.set_time.minute = req_port.set_minute;
         item_in.set_time.second = req_port.set_second;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

### rtl/ccc_time_core.sv
// Time core: holds the calendar time, applies one tick or set per word, presents the result.
// Depends on ccc_pkg and ccc_rsp_if.
module ccc_time_core (
   input  logic               clock,
   input  logic               reset,
   input  ccc_pkg::stage_type stage,
   output logic               advance,
   ccc_rsp_if.source          rsp_port
);

   ccc_pkg::time_type cur_ff;
   ccc_pkg::time_type cur_in;
   ccc_pkg::time_type ticked;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [5:0]        month_days;

   // The time register doubles as the result register; it changes only when the slot frees
   assign advance = stage.valid && (!out_valid_ff || rsp_port.ready);

   assign month_days = ccc_pkg::days_in_month(cur_ff.month, ccc_pkg::is_leap(cur_ff.year));

   // One second forward, carrying through the fields
   always_comb begin
      ticked = cur_ff;
      if (cur_ff.second < ccc_pkg::SEC_MAX) begin
         ticked.second = cur_ff.second + 6'd1;
      end else begin
         ticked.second = 6'd0;
         if (cur_ff.minute < ccc_pkg::MIN_MAX) begin
            ticked.minute = cur_ff.minute + 6'd1;
         end else begin
            ticked.minute = 6'd0;
            if (cur_ff.hour < ccc_pkg::HOUR_MAX) begin
               ticked.hour = cur_ff.hour + 5'd1;
            end else begin
               ticked.hour = 5'd0;
               if (({1'b0, cur_ff.day} + 6'd1) <= month_days) begin
                  ticked.day = cur_ff.day + 5'd1;
               end else begin
                  ticked.day = 5'd1;
                  if (cur_ff.month < ccc_pkg::MONTHS) begin
                     ticked.month = cur_ff.month + 4'd1;
                  end else begin
                     ticked.month = 4'd1;
                     if (cur_ff.year >= ccc_pkg::YEAR_LAST) begin
                        ticked.year = ccc_pkg::YEAR_WRAP;
                     end else begin
                        ticked.year = cur_ff.year + 12'd1;
                     end
                  end
               end
            end
         end
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         cur_in       = (stage.item.kind == ccc_pkg::KIND_SET) ? stage.item.set_time : ticked;
         out_valid_in = 1'b1;
      end else if (rsp_port.valid && rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.out_year   = cur_ff.year;
   assign rsp_port.out_month  = cur_ff.month;
   assign rsp_port.out_day    = cur_ff.day;
   assign rsp_port.out_hour   = cur_ff.hour;
   assign rsp_port.out_minute = cur_ff.minute;
   assign rsp_port.out_second = cur_ff.second;

endmodule

### rtl/ccc_checker.sv
// Port-level checker for the calendar clock counter, bound to the top level.
// Depends on calendar_clock_counter and its interface ports.
module ccc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] out_year,
   input logic [3:0]  out_month,
   input logic [4:0]  out_day,
   input logic [4:0]  out_hour,
   input logic [5:0]  out_minute,
   input logic [5:0]  out_second
);

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Words accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_year) && $stable(out_month)
         && $stable(out_day) && $stable(out_hour) && $stable(out_minute)
         && $stable(out_second))
      else $error("stalled response changed");

   a_max_pending: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two words in flight");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd0 |-> !rsp_valid)
      else $error("response with no word outstanding");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response slot");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .out_year   (rsp_port.out_year),
   .out_month  (rsp_port.out_month),
   .out_day    (rsp_port.out_day),
   .out_hour   (rsp_port.out_hour),
   .out_minute (rsp_port.out_minute),
   .out_second (rsp_port.out_second)
);

### verif/calendar_clock_counter_checker.sv
`timescale 1ns / 100ps
// Checker for the calendar clock counter: watches both channels and predicts the time.
// It compares each response word with the oldest prediction. Depends on ccc_pkg, ccc_req_if
// and ccc_rsp_if.
module calendar_clock_counter_checker (
   input  logic clock,
   input  logic reset,
   ccc_req_if   req_mon,
   ccc_rsp_if   rsp_mon,
   output int   error_count,
   output int   in_flight
);

   ccc_pkg::time_type now_time;
   ccc_pkg::time_type due_times[$];
   ccc_pkg::time_type want;
   ccc_pkg::time_type got;
   int                faults;
   int                outstanding;

   assign error_count = faults;
   assign in_flight   = outstanding;

   function automatic bit gregorian_leap(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int month_days(input int m, input int y);
      case (m)
         2:           return gregorian_leap(y) ? int'(ccc_pkg::FEB_LONG)
                                               : int'(ccc_pkg::FEB_SHORT);
         4, 6, 9, 11: return int'(ccc_pkg::DAYS_30);
         default:     return int'(ccc_pkg::DAYS_31);
      endcase
   endfunction

   // One second forward with carries; out-of-range fields carry as if at their maximum
   function automatic ccc_pkg::time_type advance_calendar(input ccc_pkg::time_type t);
      ccc_pkg::time_type n;
      n = t;
      if (n.second < ccc_pkg::SEC_MAX) begin
         n.second++;
         return n;
      end
      n.second = '0;
      if (n.minute < ccc_pkg::MIN_MAX) begin
         n.minute++;
         return n;
      end
      n.minute = '0;
      if (n.hour < ccc_pkg::HOUR_MAX) begin
         n.hour++;
         return n;
      end
      n.hour = '0;
      if (int'(n.day) + 1 <= month_days(int'(n.month), int'(n.year))) begin
         n.day++;
         return n;
      end
      n.day = 5'd1;
      if (int'(n.month) + 1 <= int'(ccc_pkg::MONTHS)) begin
         n.month++;
         return n;
      end
      n.month = 4'd1;
      if (int'(n.year) + 1 > int'(ccc_pkg::YEAR_LAST))
         n.year = ccc_pkg::YEAR_WRAP;
      else
         n.year++;
      return n;
   endfunction

   function automatic string stamp_text(input ccc_pkg::time_type t);
      return $sformatf("%0d-%0d-%0d %0d:%0d:%0d", t.year, t.month, t.day, t.hour,
                       t.minute, t.second);
   endfunction

   initial begin
      faults      = 0;
      outstanding = 0;
      now_time    = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         due_times.delete();
         now_time    = '0;
         outstanding <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == ccc_pkg::KIND_SET)
               now_time = '{req_mon.set_year, req_mon.set_month, req_mon.set_day,
                            req_mon.set_hour, req_mon.set_minute, req_mon.set_second};
            else
               now_time = advance_calendar(now_time);
            due_times.push_back(now_time);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.out_year, rsp_mon.out_month, rsp_mon.out_day,
                    rsp_mon.out_hour, rsp_mon.out_minute, rsp_mon.out_second};
            if (due_times.size() == 0) begin
               if (faults < 10)
                  $display("%0t: response word %s with nothing outstanding", $realtime,
                           stamp_text(got));
               faults++;
            end else begin
               want = due_times.pop_front();
               if (got.year != want.year || got.month != want.month ||
                   got.day != want.day || got.hour != want.hour ||
                   got.minute != want.minute || got.second != want.second) begin
                  if (faults < 10)
                     $display("%0t: time mismatch, expected %s, actual %s", $realtime,
                              stamp_text(want), stamp_text(got));
                  faults++;
               end
            end
         end
         outstanding <= due_times.size();
      end
   end

endmodule

### verif/calendar_clock_counter_test.sv
`timescale 1ns / 100ps
// Top of the calendar clock counter testbench: clock, reset, stimulus and verdict.
// Depends on ccc_pkg, ccc_req_if, ccc_rsp_if, calendar_clock_counter and the checker.
module calendar_clock_counter_test;

   // Bound the run well past the slowest legal pace of about 1800 words
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 1800;

   logic              clock;
   logic              reset;
   bit                quiet;
   int                cycles;
   int                errors;
   int                in_flight;
   int                sent;
   int                roll;
   ccc_pkg::time_type stamp;

   ccc_req_if req_bus ();
   ccc_rsp_if rsp_bus ();

   calendar_clock_counter uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   calendar_clock_counter_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .error_count (errors),
      .in_flight   (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stop a hung run; a stuck handshake must not hang the simulator
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response side: stall about 16 percent of the time, never during the quiet stretch
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= quiet || ($urandom_range(99) >= 16);
      end
   end

   // Offer one word at a falling edge, hold it until a rising edge accepts it,
   // and return on the next falling edge. Valid stays high between back-to-back
   // words, so it never gets two assignments in one step.
   task automatic send_word(input ccc_pkg::kind_type kind, input ccc_pkg::time_type t);
      while (!quiet && $urandom_range(99) < 16) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.set_year   <= t.year;
      req_bus.set_month  <= t.month;
      req_bus.set_day    <= t.day;
      req_bus.set_hour   <= t.hour;
      req_bus.set_minute <= t.minute;
      req_bus.set_second <= t.second;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Load a time and advance it by one second
   task automatic load_and_tick(input int y, input int mo, input int d, input int h,
                                input int mi, input int s);
      ccc_pkg::time_type t;
      t = '{12'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s)};
      send_word(ccc_pkg::KIND_SET, t);
      send_word(ccc_pkg::KIND_TICK, t);
   endtask

   initial begin
      // Drive every input to a known value before the first edge
      quiet              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.kind       = ccc_pkg::KIND_TICK;
      req_bus.set_year   = '0;
      req_bus.set_month  = '0;
      req_bus.set_day    = '0;
      req_bus.set_hour   = '0;
      req_bus.set_minute = '0;
      req_bus.set_second = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words: tick from the all-zero reset time, then the carry corners
      send_word(ccc_pkg::KIND_TICK, '0);
      load_and_tick(2023, 12, 31, 23, 59, 59);   // new year
      load_and_tick(2024, 2, 28, 23, 59, 59);    // leap February gets a 29th
      load_and_tick(1900, 2, 28, 23, 59, 59);    // century, not leap
      load_and_tick(2000, 2, 28, 23, 59, 59);    // divisible by 400, leap
      load_and_tick(2100, 12, 31, 23, 59, 59);   // year 2100 wraps to 2020
      load_and_tick(4095, 15, 31, 31, 63, 63);   // every field at its maximum
      load_and_tick(0, 0, 0, 0, 0, 0);           // every field at zero
      load_and_tick(2023, 4, 30, 23, 59, 59);    // end of a 30-day month
      load_and_tick(2023, 0, 30, 23, 59, 59);    // month zero counts 31 days
      load_and_tick(2023, 13, 31, 23, 59, 59);   // month above 12 carries the year

      // Hold the sender until every outstanding response has drained
      req_bus.valid <= 1'b0;
      while (in_flight != 0) @(negedge clock);

      // Random words: mostly ticks after sets placed close to a rollover
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         quiet        = (sent >= 700 && sent < 1000);
         roll         = $urandom_range(99);
         stamp.year   = 12'($urandom_range(4095));
         stamp.month  = 4'($urandom_range(15));
         stamp.day    = 5'($urandom_range(31));
         stamp.hour   = 5'($urandom_range(31));
         stamp.minute = 6'($urandom_range(63));
         stamp.second = 6'($urandom_range(63));
         if (roll < 8) begin
            // Raw field patterns, out-of-range values included
            send_word(ccc_pkg::KIND_SET, stamp);
         end else if (roll < 20) begin
            // A time a few seconds short of a day or month boundary; the day may pass the month length
            if ($urandom_range(3) == 0)
               stamp.year = 12'(2096 + $urandom_range(8));
            else
               stamp.year = 12'($urandom_range(1895, 2105));
            stamp.month  = 4'($urandom_range(1, 12));
            stamp.day    = 5'($urandom_range(27, 31));
            stamp.hour   = 5'($urandom_range(22, 23));
            stamp.minute = 6'($urandom_range(57, 59));
            stamp.second = 6'($urandom_range(55, 59));
            send_word(ccc_pkg::KIND_SET, stamp);
         end else begin
            // Tick with junk in the load fields, which must be ignored
            send_word(ccc_pkg::KIND_TICK, stamp);
         end
         sent++;
      end
      quiet = 1'b0;
      req_bus.valid <= 1'b0;

      // Drain, then wait a while for any stray response word
      while (in_flight != 0) @(negedge clock);
      repeat (6) @(negedge clock);

      if (errors == 0 && in_flight == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
